// ===== hdl/capbb_pkg.sv =====
// ----------------------------------------------------------------------------
// capbb_pkg
// Shared widths, result kind codes and the side payload type of the capsule
// bounding box pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package capbb_pkg;

   localparam int CoordWidth  = 32;
   localparam int RadiusWidth = 31;
   localparam int KindWidth   = 3;

   // square root row: 66-bit radicand, two bits per cell
   localparam int SqRadWidth  = 66;
   localparam int SqSteps     = 33;
   localparam int SqRootWidth = 33;
   localparam int SqRemWidth  = 38;

   // divider row
   localparam int DenWidth    = 34;
   localparam int MagWidth    = 32;

   localparam logic [KindWidth-1:0] KindCenter    = 3'd0;
   localparam logic [KindWidth-1:0] KindExtents   = 3'd1;
   localparam logic [KindWidth-1:0] KindDirection = 3'd2;
   localparam logic [KindWidth-1:0] KindRight     = 3'd3;
   localparam logic [KindWidth-1:0] KindUp        = 3'd4;

   localparam logic [2:0] HoldCycles = 3'd4;

   typedef struct packed {
      logic signed [CoordWidth-1:0]  center_x;
      logic signed [CoordWidth-1:0]  center_y;
      logic signed [CoordWidth-1:0]  center_z;
      logic [RadiusWidth-1:0]        radius;
      logic [CoordWidth-1:0]         ext_x;
      logic                          degenerate;
      logic [2:0]                    neg;
      logic [2:0][MagWidth-1:0]      mag;
      logic signed [CoordWidth-1:0]  dir_x;
      logic signed [CoordWidth-1:0]  dir_y;
      logic signed [CoordWidth-1:0]  dir_z;
   } side_type;

endpackage

`default_nettype wire

// ===== hdl/capbb_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// capbb_sqrt_cell
// One cell of the square root row: takes two radicand bits, yields one root
// bit per lane, and hands the side payload on.
// ----------------------------------------------------------------------------
`default_nettype none

module capbb_sqrt_cell #(
   parameter int LANES = 1
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           src_valid,
   input  capbb_pkg::side_type                            src_side,
   input  logic [LANES-1:0][capbb_pkg::SqRadWidth-1:0]    src_rad,
   input  logic [LANES-1:0][capbb_pkg::SqRemWidth-1:0]    src_rem,
   input  logic [LANES-1:0][capbb_pkg::SqRootWidth-1:0]   src_root,
   output logic                                           dst_valid,
   output capbb_pkg::side_type                            dst_side,
   output logic [LANES-1:0][capbb_pkg::SqRadWidth-1:0]    dst_rad,
   output logic [LANES-1:0][capbb_pkg::SqRemWidth-1:0]    dst_rem,
   output logic [LANES-1:0][capbb_pkg::SqRootWidth-1:0]   dst_root
);

   localparam int RadW  = capbb_pkg::SqRadWidth;
   localparam int RemW  = capbb_pkg::SqRemWidth;
   localparam int RootW = capbb_pkg::SqRootWidth;

   logic                                valid_ff;
   capbb_pkg::side_type                 side_ff;
   logic [LANES-1:0][RadW-1:0]          rad_ff, rad_in;
   logic [LANES-1:0][RemW-1:0]          rem_ff, rem_in;
   logic [LANES-1:0][RootW-1:0]         root_ff, root_in;

   always_comb begin
      logic [RemW-1:0] rem_t;
      logic [RemW-1:0] trial;
      for (int l = 0; l < LANES; l++) begin
         rem_t = {src_rem[l][RemW-3:0], src_rad[l][RadW-1 -: 2]};
         trial = {{(RemW-RootW-2){1'b0}}, src_root[l], 2'b01};
         rad_in[l] = {src_rad[l][RadW-3:0], 2'b00};
         if (rem_t >= trial) begin
            rem_in[l]  = rem_t - trial;
            root_in[l] = {src_root[l][RootW-2:0], 1'b1};
         end else begin
            rem_in[l]  = rem_t;
            root_in[l] = {src_root[l][RootW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= src_side;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign dst_valid = valid_ff;
   assign dst_side  = side_ff;
   assign dst_rad   = rad_ff;
   assign dst_rem   = rem_ff;
   assign dst_root  = root_ff;

endmodule

`default_nettype wire

// ===== hdl/capbb_div_cell.sv =====
// ----------------------------------------------------------------------------
// capbb_div_cell
// One cell of the divider row: one restoring step and one quotient bit for
// each of three lanes over a shared divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module capbb_div_cell #(
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  src_valid,
   input  capbb_pkg::side_type                   src_side,
   input  logic [capbb_pkg::DenWidth-1:0]        src_den,
   input  logic [2:0][capbb_pkg::DenWidth-1:0]   src_rem,
   input  logic [2:0][FRAC_BITS:0]               src_low,
   input  logic [2:0][FRAC_BITS:0]               src_quo,
   output logic                                  dst_valid,
   output capbb_pkg::side_type                   dst_side,
   output logic [capbb_pkg::DenWidth-1:0]        dst_den,
   output logic [2:0][capbb_pkg::DenWidth-1:0]   dst_rem,
   output logic [2:0][FRAC_BITS:0]               dst_low,
   output logic [2:0][FRAC_BITS:0]               dst_quo
);

   localparam int DenW = capbb_pkg::DenWidth;

   logic                        valid_ff;
   capbb_pkg::side_type         side_ff;
   logic [DenW-1:0]             den_ff;
   logic [2:0][DenW-1:0]        rem_ff, rem_in;
   logic [2:0][FRAC_BITS:0]     low_ff, low_in;
   logic [2:0][FRAC_BITS:0]     quo_ff, quo_in;

   always_comb begin
      logic [DenW:0] r_t;
      logic [DenW:0] d_t;
      logic [DenW:0] diff;
      d_t = {1'b0, src_den};
      for (int l = 0; l < 3; l++) begin
         r_t  = {src_rem[l], src_low[l][FRAC_BITS]};
         diff = r_t - d_t;
         low_in[l] = {src_low[l][FRAC_BITS-1:0], 1'b0};
         if (r_t >= d_t) begin
            rem_in[l] = diff[DenW-1:0];
            quo_in[l] = {src_quo[l][FRAC_BITS-1:0], 1'b1};
         end else begin
            rem_in[l] = r_t[DenW-1:0];
            quo_in[l] = {src_quo[l][FRAC_BITS-1:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      side_ff <= src_side;
      den_ff  <= src_den;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
   end

   assign dst_valid = valid_ff;
   assign dst_side  = side_ff;
   assign dst_den   = den_ff;
   assign dst_rem   = rem_ff;
   assign dst_low   = low_ff;
   assign dst_quo   = quo_ff;

endmodule

`default_nettype wire

// ===== hdl/capsule_bounding_box.sv =====
// ----------------------------------------------------------------------------
// capsule_bounding_box
// Oriented bounding box of a capsule: center, extents, axis direction, right
// and up vectors, sent as five transactions per capsule.
//
//   channel   ports                       handshake
//   request   req_*, start, busy          taken when start and not busy
//   response  rsp_*, rsp_strobe           one vector per cycle, no stall
//
// a new capsule can be accepted while earlier ones are still in the pipeline;
// busy is loaded from HoldCycles at each accepted transaction and counts down,
// spacing capsules so that their five response vectors do not overlap.
// the path runs through the two square root rows (33 cells each), the two
// divider rows (FRAC_BITS+1 cells each) and fourteen pipeline registers.
// reset clears all valid flags; the response side cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module capsule_bounding_box #(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [31:0]  req_first_x,
   input  logic signed [31:0]  req_first_y,
   input  logic signed [31:0]  req_first_z,
   input  logic signed [31:0]  req_second_x,
   input  logic signed [31:0]  req_second_y,
   input  logic signed [31:0]  req_second_z,
   input  logic [30:0]         req_cap_radius,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_vector_kind,
   output logic signed [31:0]  rsp_vec_x,
   output logic signed [31:0]  rsp_vec_y,
   output logic signed [31:0]  rsp_vec_z,
   output logic                rsp_degenerate,
   output logic                rsp_last_vector
);

   localparam int RadW   = capbb_pkg::SqRadWidth;
   localparam int RemW   = capbb_pkg::SqRemWidth;
   localparam int RootW  = capbb_pkg::SqRootWidth;
   localparam int SqN    = capbb_pkg::SqSteps;
   localparam int DenW   = capbb_pkg::DenWidth;
   localparam int MagW   = capbb_pkg::MagWidth;
   localparam int DivN   = FRAC_BITS + 1;
   localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic [32:0] ExtMax = 33'h07FFFFFFF;
   localparam logic [1:0] AxisX = 2'd0;
   localparam logic [1:0] AxisY = 2'd1;
   localparam logic [1:0] AxisZ = 2'd2;

   // request capture and busy
   logic              accept;
   logic [2:0]        busy_ff, busy_in;
   logic              s0_valid_ff;
   logic [2:0][31:0]  s0_a_ff, s0_b_ff;
   logic [30:0]       s0_rad_ff;

   assign accept = start & ~busy;
   assign busy   = (busy_ff != 3'd0);

   always_comb begin
      if (accept) begin
         busy_in = capbb_pkg::HoldCycles;
      end else if (busy) begin
         busy_in = busy_ff - 3'd1;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 3'd0;
         s0_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_a_ff   <= {req_first_z, req_first_y, req_first_x};
         s0_b_ff   <= {req_second_z, req_second_y, req_second_x};
         s0_rad_ff <= req_cap_radius;
      end
   end

   // stage 1: difference, center, magnitudes
   logic                    s1_valid_ff;
   capbb_pkg::side_type     s1_side_ff, s1_side_in;
   logic [2:0][MagW-1:0]    s1_mag_ff, s1_mag_in;
   logic [MagW-1:0]         s1_max_ff, s1_max_in;

   always_comb begin
      logic [32:0] diff;
      logic [32:0] total;
      logic [32:0] absd;
      logic [2:0][31:0] cen;
      s1_side_in = '0;
      s1_max_in  = '0;
      for (int i = 0; i < 3; i++) begin
         diff  = {s0_b_ff[i][31], s0_b_ff[i]} - {s0_a_ff[i][31], s0_a_ff[i]};
         total = {s0_b_ff[i][31], s0_b_ff[i]} + {s0_a_ff[i][31], s0_a_ff[i]};
         absd  = diff[32] ? (33'd0 - diff) : diff;
         cen[i] = total[32:1];
         s1_side_in.neg[i] = diff[32];
         s1_mag_in[i] = absd[31:0];
         if (absd[31:0] > s1_max_in) begin
            s1_max_in = absd[31:0];
         end
      end
      s1_side_in.center_x   = cen[0];
      s1_side_in.center_y   = cen[1];
      s1_side_in.center_z   = cen[2];
      s1_side_in.radius     = s0_rad_ff;
      s1_side_in.degenerate = (s1_max_in == '0);
   end

   // stage 2: squares and normalising shift
   logic                    s2_valid_ff;
   capbb_pkg::side_type     s2_side_ff;
   logic [2:0][MagW-1:0]    s2_mag_ff;
   logic [2:0][63:0]        s2_sq_ff, s2_sq_in;
   logic [4:0]              s2_k_ff, s2_k_in;

   always_comb begin
      s2_k_in = 5'd0;
      for (int i = 0; i < MagW; i++) begin
         if (s1_max_ff[i]) begin
            s2_k_in = 5'(MagW - 1 - i);
         end
      end
      for (int i = 0; i < 3; i++) begin
         s2_sq_in[i] = s1_mag_ff[i] * s1_mag_ff[i];
      end
   end

   // stage 3: sum for axis length, shifted magnitudes
   logic                    s3_valid_ff;
   capbb_pkg::side_type     s3_side_ff;
   logic [RadW-1:0]         s3_sum_ff;
   logic [2:0][MagW-1:0]    s3_sh_ff, s3_sh_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_sh_in[i] = s2_mag_ff[i] << s2_k_ff;
      end
   end

   // stage 4: squares of the shifted magnitudes
   logic                    s4_valid_ff;
   capbb_pkg::side_type     s4_side_ff, s4_side_in;
   logic [RadW-1:0]         s4_sum_ff;
   logic [2:0][63:0]        s4_sq_ff, s4_sq_in;

   always_comb begin
      s4_side_in     = s3_side_ff;
      s4_side_in.mag = s3_sh_ff;
      for (int i = 0; i < 3; i++) begin
         s4_sq_in[i] = s3_sh_ff[i] * s3_sh_ff[i];
      end
   end

   // stage 5: radicands for the first root row
   logic                        s5_valid_ff;
   capbb_pkg::side_type         s5_side_ff;
   logic [1:0][RadW-1:0]        s5_rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_side_ff <= s1_side_in;
      s1_mag_ff  <= s1_mag_in;
      s1_max_ff  <= s1_max_in;
      s2_side_ff <= s1_side_ff;
      s2_mag_ff  <= s1_mag_ff;
      s2_sq_ff   <= s2_sq_in;
      s2_k_ff    <= s2_k_in;
      s3_side_ff <= s2_side_ff;
      s3_sum_ff  <= {2'b00, s2_sq_ff[0]} + {2'b00, s2_sq_ff[1]} + {2'b00, s2_sq_ff[2]};
      s3_sh_ff   <= s3_sh_in;
      s4_side_ff <= s4_side_in;
      s4_sum_ff  <= s3_sum_ff;
      s4_sq_ff   <= s4_sq_in;
      s5_side_ff <= s4_side_ff;
      s5_rad_ff  <= {{2'b00, s4_sq_ff[0]} + {2'b00, s4_sq_ff[1]} + {2'b00, s4_sq_ff[2]},
                     s4_sum_ff};
   end

   // first root row: lane 0 axis length, lane 1 normalised length
   logic                          r1_valid [SqN+1];
   capbb_pkg::side_type           r1_side  [SqN+1];
   logic [1:0][RadW-1:0]          r1_rad   [SqN+1];
   logic [1:0][RemW-1:0]          r1_rem   [SqN+1];
   logic [1:0][RootW-1:0]         r1_root  [SqN+1];

   assign r1_valid[0] = s5_valid_ff;
   assign r1_side[0]  = s5_side_ff;
   assign r1_rad[0]   = s5_rad_ff;
   assign r1_rem[0]   = '0;
   assign r1_root[0]  = '0;

   for (genvar j = 0; j < SqN; j++) begin : g_root1
      capbb_sqrt_cell #(.LANES(2)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (r1_valid[j]),
         .src_side  (r1_side[j]),
         .src_rad   (r1_rad[j]),
         .src_rem   (r1_rem[j]),
         .src_root  (r1_root[j]),
         .dst_valid (r1_valid[j+1]),
         .dst_side  (r1_side[j+1]),
         .dst_rad   (r1_rad[j+1]),
         .dst_rem   (r1_rem[j+1]),
         .dst_root  (r1_root[j+1])
      );
   end

   // extents and first divider set-up
   logic                          d1_valid [DivN+1];
   capbb_pkg::side_type           d1_side  [DivN+1];
   logic [DenW-1:0]               d1_den   [DivN+1];
   logic [2:0][DenW-1:0]          d1_rem   [DivN+1];
   logic [2:0][FRAC_BITS:0]       d1_low   [DivN+1];
   logic [2:0][FRAC_BITS:0]       d1_quo   [DivN+1];

   always_comb begin
      logic [32:0] ext;
      logic [63:0] num;
      logic [63:0] num_sh;
      ext = {2'b00, r1_side[SqN].radius} + {1'b0, r1_root[SqN][0][RootW-1:1]};
      d1_side[0] = r1_side[SqN];
      d1_side[0].ext_x = (ext > ExtMax) ? ExtMax[31:0] : ext[31:0];
      d1_den[0] = {{(DenW-RootW){1'b0}}, r1_root[SqN][1]};
      for (int i = 0; i < 3; i++) begin
         num    = (64'(r1_side[SqN].mag[i]) << FRAC_BITS) + 64'(d1_den[0][DenW-1:1]);
         num_sh = num >> (FRAC_BITS + 1);
         d1_rem[0][i] = num_sh[DenW-1:0];
         d1_low[0][i] = num[FRAC_BITS:0];
      end
   end

   assign d1_valid[0] = r1_valid[SqN];
   assign d1_quo[0]   = '0;

   for (genvar j = 0; j < DivN; j++) begin : g_div1
      capbb_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (d1_valid[j]),
         .src_side  (d1_side[j]),
         .src_den   (d1_den[j]),
         .src_rem   (d1_rem[j]),
         .src_low   (d1_low[j]),
         .src_quo   (d1_quo[j]),
         .dst_valid (d1_valid[j+1]),
         .dst_side  (d1_side[j+1]),
         .dst_den   (d1_den[j+1]),
         .dst_rem   (d1_rem[j+1]),
         .dst_low   (d1_low[j+1]),
         .dst_quo   (d1_quo[j+1])
      );
   end

   // stage 7: direction, axis choice, raw right
   logic                    s7_valid_ff;
   capbb_pkg::side_type     s7_side_ff, s7_side_in;

   always_comb begin
      logic [2:0][31:0] q;
      logic [2:0][31:0] dir;
      logic [1:0]       axis;
      logic [2:0]       n;
      s7_side_in = d1_side[DivN];
      n = d1_side[DivN].neg;
      for (int i = 0; i < 3; i++) begin
         q[i]   = d1_side[DivN].degenerate ? 32'd0 : 32'(d1_quo[DivN][i]);
         dir[i] = n[i] ? (32'd0 - q[i]) : q[i];
      end
      axis = AxisX;
      if (q[1] > q[0]) begin
         axis = AxisY;
      end
      if ((axis == AxisY && q[2] > q[1]) || (axis == AxisX && q[2] > q[0])) begin
         axis = AxisZ;
      end
      s7_side_in.dir_x = dir[0];
      s7_side_in.dir_y = dir[1];
      s7_side_in.dir_z = dir[2];
      case (axis)
         AxisX: begin
            s7_side_in.mag = {32'd0, q[0], q[1]};
            s7_side_in.neg = {1'b0, n[0], ~n[1]};
         end
         AxisY: begin
            s7_side_in.mag = {q[1], q[2], 32'd0};
            s7_side_in.neg = {n[1], ~n[2], 1'b0};
         end
         default: begin
            s7_side_in.mag = {q[0], 32'd0, q[2]};
            s7_side_in.neg = {~n[0], 1'b0, n[2]};
         end
      endcase
   end

   // stages 8 and 9: sum of squares of raw right
   logic                    s8_valid_ff;
   capbb_pkg::side_type     s8_side_ff;
   logic [2:0][63:0]        s8_sq_ff, s8_sq_in;
   logic                    s9_valid_ff;
   capbb_pkg::side_type     s9_side_ff;
   logic [0:0][RadW-1:0]    s9_rad_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s8_sq_in[i] = s7_side_ff.mag[i] * s7_side_ff.mag[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= d1_valid[DivN];
         s8_valid_ff <= s7_valid_ff;
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_side_ff <= s7_side_in;
      s8_side_ff <= s7_side_ff;
      s8_sq_ff   <= s8_sq_in;
      s9_side_ff <= s8_side_ff;
      s9_rad_ff  <= {2'b00, s8_sq_ff[0]} + {2'b00, s8_sq_ff[1]} + {2'b00, s8_sq_ff[2]};
   end

   // second root row
   logic                          r2_valid [SqN+1];
   capbb_pkg::side_type           r2_side  [SqN+1];
   logic [0:0][RadW-1:0]          r2_rad   [SqN+1];
   logic [0:0][RemW-1:0]          r2_rem   [SqN+1];
   logic [0:0][RootW-1:0]         r2_root  [SqN+1];

   assign r2_valid[0] = s9_valid_ff;
   assign r2_side[0]  = s9_side_ff;
   assign r2_rad[0]   = s9_rad_ff;
   assign r2_rem[0]   = '0;
   assign r2_root[0]  = '0;

   for (genvar j = 0; j < SqN; j++) begin : g_root2
      capbb_sqrt_cell #(.LANES(1)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (r2_valid[j]),
         .src_side  (r2_side[j]),
         .src_rad   (r2_rad[j]),
         .src_rem   (r2_rem[j]),
         .src_root  (r2_root[j]),
         .dst_valid (r2_valid[j+1]),
         .dst_side  (r2_side[j+1]),
         .dst_rad   (r2_rad[j+1]),
         .dst_rem   (r2_rem[j+1]),
         .dst_root  (r2_root[j+1])
      );
   end

   // second divider row
   logic                          d2_valid [DivN+1];
   capbb_pkg::side_type           d2_side  [DivN+1];
   logic [DenW-1:0]               d2_den   [DivN+1];
   logic [2:0][DenW-1:0]          d2_rem   [DivN+1];
   logic [2:0][FRAC_BITS:0]       d2_low   [DivN+1];
   logic [2:0][FRAC_BITS:0]       d2_quo   [DivN+1];

   always_comb begin
      logic [63:0] num;
      logic [63:0] num_sh;
      d2_den[0] = {{(DenW-RootW){1'b0}}, r2_root[SqN][0]};
      for (int i = 0; i < 3; i++) begin
         num    = (64'(r2_side[SqN].mag[i]) << FRAC_BITS) + 64'(d2_den[0][DenW-1:1]);
         num_sh = num >> (FRAC_BITS + 1);
         d2_rem[0][i] = num_sh[DenW-1:0];
         d2_low[0][i] = num[FRAC_BITS:0];
      end
   end

   assign d2_valid[0] = r2_valid[SqN];
   assign d2_side[0]  = r2_side[SqN];
   assign d2_quo[0]   = '0;

   for (genvar j = 0; j < DivN; j++) begin : g_div2
      capbb_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_valid (d2_valid[j]),
         .src_side  (d2_side[j]),
         .src_den   (d2_den[j]),
         .src_rem   (d2_rem[j]),
         .src_low   (d2_low[j]),
         .src_quo   (d2_quo[j]),
         .dst_valid (d2_valid[j+1]),
         .dst_side  (d2_side[j+1]),
         .dst_den   (d2_den[j+1]),
         .dst_rem   (d2_rem[j+1]),
         .dst_low   (d2_low[j+1]),
         .dst_quo   (d2_quo[j+1])
      );
   end

   // stages 10 to 12: right vector, cross product, rounding
   logic                    s10_valid_ff;
   capbb_pkg::side_type     s10_side_ff;
   logic [2:0][31:0]        s10_right_ff, s10_right_in;
   logic                    s11_valid_ff;
   capbb_pkg::side_type     s11_side_ff;
   logic [2:0][31:0]        s11_right_ff;
   logic [5:0][63:0]        s11_prod_ff, s11_prod_in;
   logic                    s12_valid_ff;
   capbb_pkg::side_type     s12_side_ff;
   logic [2:0][31:0]        s12_right_ff;
   logic [2:0][31:0]        s12_up_ff, s12_up_in;

   always_comb begin
      logic [31:0] q;
      for (int i = 0; i < 3; i++) begin
         q = d2_side[DivN].degenerate ? 32'd0 : 32'(d2_quo[DivN][i]);
         s10_right_in[i] = d2_side[DivN].neg[i] ? (32'd0 - q) : q;
      end
   end

   always_comb begin
      s11_prod_in[0] = s10_side_ff.dir_y * $signed(s10_right_ff[2]);
      s11_prod_in[1] = s10_side_ff.dir_z * $signed(s10_right_ff[1]);
      s11_prod_in[2] = s10_side_ff.dir_z * $signed(s10_right_ff[0]);
      s11_prod_in[3] = s10_side_ff.dir_x * $signed(s10_right_ff[2]);
      s11_prod_in[4] = s10_side_ff.dir_x * $signed(s10_right_ff[1]);
      s11_prod_in[5] = s10_side_ff.dir_y * $signed(s10_right_ff[0]);
   end

   always_comb begin
      logic signed [63:0] p;
      logic signed [63:0] t;
      for (int i = 0; i < 3; i++) begin
         p = $signed(s11_prod_ff[2*i]) - $signed(s11_prod_ff[2*i+1]);
         t = (p + Half) >>> FRAC_BITS;
         s12_up_in[i] = t[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
         s11_valid_ff <= 1'b0;
         s12_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= d2_valid[DivN];
         s11_valid_ff <= s10_valid_ff;
         s12_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s10_side_ff  <= d2_side[DivN];
      s10_right_ff <= s10_right_in;
      s11_side_ff  <= s10_side_ff;
      s11_right_ff <= s10_right_ff;
      s11_prod_ff  <= s11_prod_in;
      s12_side_ff  <= s11_side_ff;
      s12_right_ff <= s11_right_ff;
      s12_up_ff    <= s12_up_in;
   end

   // response serialiser
   logic [2:0][31:0]   hold_ff [5];
   logic               hold_deg_ff;
   logic               send_ff;
   logic [2:0]         kind_ff;
   logic               strobe_ff;
   logic [2:0]         rsp_kind_ff;
   logic [2:0][31:0]   rsp_vec_ff;
   logic               rsp_deg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         send_ff   <= 1'b0;
         kind_ff   <= capbb_pkg::KindCenter;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= send_ff;
         if (s12_valid_ff) begin
            send_ff <= 1'b1;
            kind_ff <= capbb_pkg::KindCenter;
         end else if (send_ff) begin
            kind_ff <= kind_ff + 3'd1;
            if (kind_ff == capbb_pkg::KindUp) begin
               send_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s12_valid_ff) begin
         hold_ff[0]  <= {s12_side_ff.center_z, s12_side_ff.center_y, s12_side_ff.center_x};
         hold_ff[1]  <= {32'(s12_side_ff.radius), 32'(s12_side_ff.radius),
                         s12_side_ff.ext_x};
         hold_ff[2]  <= {s12_side_ff.dir_z, s12_side_ff.dir_y, s12_side_ff.dir_x};
         hold_ff[3]  <= s12_right_ff;
         hold_ff[4]  <= s12_up_ff;
         hold_deg_ff <= s12_side_ff.degenerate;
      end
      rsp_kind_ff <= kind_ff;
      rsp_vec_ff  <= hold_ff[kind_ff];
      rsp_deg_ff  <= hold_deg_ff;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_vector_kind = rsp_kind_ff;
   assign rsp_vec_x       = rsp_vec_ff[0];
   assign rsp_vec_y       = rsp_vec_ff[1];
   assign rsp_vec_z       = rsp_vec_ff[2];
   assign rsp_degenerate  = rsp_deg_ff;
   assign rsp_last_vector = (rsp_kind_ff == capbb_pkg::KindUp);

endmodule

`default_nettype wire
